// ===== rtl/esd_pkg.sv =====
// Shared types, character constants and escape lookup for the escape sequence decoder.
// No dependencies; used by the channel interfaces and imported by the decoder.
package esd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [2:0] pass_type;
   typedef logic [1:0] count_type;

   typedef enum logic [1:0] {
      MODE_NORMAL  = 2'd0,
      MODE_ESCAPE  = 2'd1,
      MODE_UNICODE = 2'd2
   } mode_type;

   localparam byte_type CHAR_BACKSLASH = 8'h5C;
   localparam byte_type CHAR_U         = 8'h75;
   localparam byte_type CHAR_SLASH     = 8'h2F;
   localparam byte_type CHAR_QUOTE     = 8'h22;
   localparam byte_type CHAR_A         = 8'h61;
   localparam byte_type CHAR_B         = 8'h62;
   localparam byte_type CHAR_F         = 8'h66;
   localparam byte_type CHAR_N         = 8'h6E;
   localparam byte_type CHAR_R         = 8'h72;
   localparam byte_type CHAR_T         = 8'h74;
   localparam byte_type CODE_BEL       = 8'h07;
   localparam byte_type CODE_BS        = 8'h08;
   localparam byte_type CODE_FF        = 8'h0C;
   localparam byte_type CODE_LF        = 8'h0A;
   localparam byte_type CODE_CR        = 8'h0D;
   localparam byte_type CODE_TAB       = 8'h09;

   localparam pass_type  UNICODE_DIGITS = 3'd4;
   localparam count_type QUEUE_DEPTH    = 2'd2;

   typedef struct packed {
      logic     hit;
      byte_type value;
   } escape_type;

   typedef struct packed {
      byte_type value;
      logic     run_end;
      logic     string_end;
   } result_type;

   function automatic escape_type escape_map(input byte_type b);
      escape_type e;
      e.hit   = 1'b1;
      e.value = b;
      unique case (b)
         CHAR_SLASH:     e.value = CHAR_SLASH;
         CHAR_QUOTE:     e.value = CHAR_QUOTE;
         CHAR_A:         e.value = CODE_BEL;
         CHAR_B:         e.value = CODE_BS;
         CHAR_F:         e.value = CODE_FF;
         CHAR_N:         e.value = CODE_LF;
         CHAR_R:         e.value = CODE_CR;
         CHAR_T:         e.value = CODE_TAB;
         CHAR_BACKSLASH: e.value = CHAR_BACKSLASH;
         default:        e.hit   = 1'b0;
      endcase
      return e;
   endfunction

endpackage

// ===== rtl/esd_channels.sv =====
// Valid/ready channel interfaces for the escape sequence decoder requests and results.
// Depends on esd_pkg for the byte type.
interface esd_req_if;
   logic               valid;
   logic               ready;
   esd_pkg::byte_type  in_byte;
   logic               in_last;

   modport source(output valid, in_byte, in_last, input ready);
   modport sink(input valid, in_byte, in_last, output ready);
endinterface

interface esd_rsp_if;
   logic               valid;
   logic               ready;
   esd_pkg::byte_type  out_byte;
   logic               out_run_end;
   logic               out_string_end;

   modport source(output valid, out_byte, out_run_end, out_string_end, input ready);
   modport sink(input valid, out_byte, out_run_end, out_string_end, output ready);
endinterface

// ===== rtl/escape_sequence_decoder.sv =====
// Backslash escape decoder: one escaped byte per request, zero to two decoded bytes out.
// Depends on esd_pkg and the channel interfaces in esd_channels.sv.
//
// Channels: req_chan takes one raw byte per request with in_last on the final byte of
// a string. rsp_chan gives decoded bytes; out_run_end marks the last result of one
// request, out_string_end the final decoded byte of the string.
// Path: a request is registered in the input stage when accepted, decoded into a
// two-entry result queue once the queue has room for its results, and shown on
// rsp_chan from the head of the queue.
// Throughput: one request per cycle while each yields at most one result and rsp_chan
// does not stall. A request that yields two results needs both queue slots, which the
// result port drains one per cycle, so a run of them is taken only as the queue drains.
// A request that yields no result (a pending backslash) still occupies the input stage.
// Reset clears the decode mode, the unicode pass count, the input valid flag and the
// queue count, not the held byte or queue slots. When rsp_chan stalls, results hold in
// the queue and req_chan ready drops once the queue cannot take the held request's results.
module escape_sequence_decoder (
   input  logic              clock,
   input  logic              reset,
   esd_req_if.sink           req_chan,
   esd_rsp_if.source         rsp_chan
);
   import esd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   byte_type   in_byte_ff, in_byte_in;
   logic       in_last_ff, in_last_in;
   mode_type   mode_ff, mode_in;
   pass_type   pass_ff, pass_in;
   count_type  count_ff, count_in;
   result_type slot0_ff, slot0_in;
   result_type slot1_ff, slot1_in;

   result_type r0, r1;
   count_type  n;
   mode_type   mode_next;
   pass_type   pass_next;
   escape_type esc;
   count_type  count_mid;
   logic [2:0] fill;
   logic       pop, consume, accept;

   always_comb begin
      esc       = escape_map(in_byte_ff);
      r0        = '{value: in_byte_ff, run_end: 1'b1, string_end: in_last_ff};
      r1        = '{value: in_byte_ff, run_end: 1'b1, string_end: in_last_ff};
      n         = 2'd1;
      mode_next = MODE_NORMAL;
      pass_next = pass_ff;
      unique case (mode_ff)
         MODE_UNICODE: begin
            if (pass_ff > 3'd1) begin
               mode_next = MODE_UNICODE;
               pass_next = pass_ff - 3'd1;
            end else begin
               pass_next = '0;
            end
         end
         MODE_ESCAPE: begin
            if (esc.hit) begin
               r0.value = esc.value;
            end else if (in_byte_ff == CHAR_U) begin
               r0        = '{value: CHAR_BACKSLASH, run_end: 1'b0, string_end: 1'b0};
               n         = 2'd2;
               mode_next = MODE_UNICODE;
               pass_next = UNICODE_DIGITS;
            end else begin
               r0 = '{value: CHAR_BACKSLASH, run_end: 1'b0, string_end: 1'b0};
               n  = 2'd2;
            end
         end
         default: begin
            if (in_byte_ff == CHAR_BACKSLASH && !in_last_ff) begin
               n         = 2'd0;
               mode_next = MODE_ESCAPE;
            end
         end
      endcase
      if (in_last_ff) begin
         mode_next = MODE_NORMAL;
         pass_next = '0;
      end
   end

   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign count_mid = count_ff - {1'b0, pop};
   assign fill      = {1'b0, count_mid} + {1'b0, n};
   assign consume   = in_valid_ff && (fill <= {1'b0, QUEUE_DEPTH});
   assign accept    = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_valid_ff || consume;

   always_comb begin
      in_valid_in = (in_valid_ff && !consume) || accept;
      in_byte_in  = accept ? req_chan.in_byte : in_byte_ff;
      in_last_in  = accept ? req_chan.in_last : in_last_ff;
      mode_in     = consume ? mode_next : mode_ff;
      pass_in     = consume ? pass_next : pass_ff;
      slot0_in    = pop ? slot1_ff : slot0_ff;
      slot1_in    = slot1_ff;
      count_in    = count_mid;
      if (consume) begin
         count_in = fill[1:0];
         if (count_mid == 2'd0) begin
            slot0_in = r0;
            slot1_in = r1;
         end else if (count_mid == 2'd1) begin
            slot1_in = r0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         mode_ff     <= MODE_NORMAL;
         pass_ff     <= '0;
         count_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         mode_ff     <= mode_in;
         pass_ff     <= pass_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      in_last_ff <= in_last_in;
      slot0_ff   <= slot0_in;
      slot1_ff   <= slot1_in;
   end

   assign rsp_chan.valid          = count_ff != 2'd0;
   assign rsp_chan.out_byte       = slot0_ff.value;
   assign rsp_chan.out_run_end    = slot0_ff.run_end;
   assign rsp_chan.out_string_end = slot0_ff.string_end;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// Testbench for escape_sequence_decoder: sends escaped strings one request per byte and
// checks each decoded byte against an in-bench decode model with its own mode state.
// Depends on esd_pkg, esd_channels.sv and the decoder RTL.
module tb;
   import esd_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int SETTLE_CYCLES   = 20;
   localparam int RANDOM_REQUESTS = 1400;
   localparam int LONG_HOLD       = 300;
   localparam int MAX_GAP         = 14;

   typedef enum int {
      PIECE_PLAIN,
      PIECE_ESCAPE,
      PIECE_UNKNOWN,
      PIECE_UNICODE,
      PIECE_LONE
   } piece_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   esd_req_if req_chan();
   esd_rsp_if rsp_chan();

   escape_sequence_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   mode_type   model_mode   = MODE_NORMAL;
   pass_type   model_digits = '0;
   result_type decoded_bytes[$];

   byte_type escape_letters[9] = '{CHAR_SLASH, CHAR_QUOTE, CHAR_A, CHAR_B, CHAR_F,
                                   CHAR_N, CHAR_R, CHAR_T, CHAR_BACKSLASH};

   int cycle_count    = 0;
   int mismatch_count = 0;
   int request_count  = 0;
   int result_count   = 0;
   int string_count   = 0;
   int sink_hold      = 0;
   bit source_gaps    = 1'b0;
   bit sink_gaps      = 1'b0;

   function automatic void expect_byte(byte_type value, logic run_end, logic string_end);
      result_type r;
      r.value      = value;
      r.run_end    = run_end;
      r.string_end = string_end;
      decoded_bytes.push_back(r);
   endfunction

   function automatic void decode_request(byte_type b, logic last);
      logic     hit;
      byte_type mapped;
      hit    = 1'b1;
      mapped = b;
      case (b)
         CHAR_A:                                 mapped = CODE_BEL;
         CHAR_B:                                 mapped = CODE_BS;
         CHAR_F:                                 mapped = CODE_FF;
         CHAR_N:                                 mapped = CODE_LF;
         CHAR_R:                                 mapped = CODE_CR;
         CHAR_T:                                 mapped = CODE_TAB;
         CHAR_SLASH, CHAR_QUOTE, CHAR_BACKSLASH: mapped = b;
         default:                                hit = 1'b0;
      endcase
      case (model_mode)
         MODE_UNICODE: begin
            expect_byte(b, 1'b1, last);
            if (model_digits <= 1 || last) begin
               model_mode   = MODE_NORMAL;
               model_digits = '0;
            end else begin
               model_digits = model_digits - 1'b1;
            end
         end
         MODE_ESCAPE: begin
            if (hit) begin
               expect_byte(mapped, 1'b1, last);
               model_mode = MODE_NORMAL;
            end else begin
               expect_byte(CHAR_BACKSLASH, 1'b0, 1'b0);
               expect_byte(b, 1'b1, last);
               if (b == CHAR_U && !last) begin
                  model_mode   = MODE_UNICODE;
                  model_digits = UNICODE_DIGITS;
               end else begin
                  model_mode = MODE_NORMAL;
               end
            end
         end
         default: begin
            if (b == CHAR_BACKSLASH && !last) begin
               model_mode = MODE_ESCAPE;
            end else begin
               expect_byte(b, 1'b1, last);
               model_mode = MODE_NORMAL;
            end
         end
      endcase
      if (last) begin
         model_mode   = MODE_NORMAL;
         model_digits = '0;
      end
   endfunction

   always @(posedge clock) begin : check_results
      result_type got;
      result_type want;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            decode_request(req_chan.in_byte, req_chan.in_last);
            request_count++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.value      = rsp_chan.out_byte;
            got.run_end    = rsp_chan.out_run_end;
            got.string_end = rsp_chan.out_string_end;
            result_count++;
            if (decoded_bytes.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result %0d: byte %02h run_end %b string_end %b",
                           result_count, got.value, got.run_end, got.string_end);
            end else begin
               want = decoded_bytes.pop_front();
               if (got.value !== want.value || got.run_end !== want.run_end ||
                   got.string_end !== want.string_end) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch at result %0d: expected byte %02h run_end %b ",
                               "string_end %b, got byte %02h run_end %b string_end %b"},
                              result_count, want.value, want.run_end, want.string_end,
                              got.value, got.run_end, got.string_end);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, decoded_bytes.size());
         $display("escape_sequence_decoder test failed");
         $finish;
      end
   end

   initial begin : result_sink
      int stall;
      rsp_chan.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (sink_hold) @(posedge clock);
            sink_hold = 0;
         end
         stall = sink_gaps ? $urandom_range(0, MAX_GAP) : 0;
         if (stall > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do begin
            @(posedge clock);
         end while (!rsp_chan.valid);
      end
   end

   task automatic send_request(input byte_type b, input logic last);
      int gap;
      gap = source_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= b;
      req_chan.in_last <= last;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   task automatic send_string(input byte_type text[$]);
      foreach (text[i]) send_request(text[i], i == text.size() - 1);
      string_count++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (decoded_bytes.size() != 0) @(posedge clock);
   endtask

   task automatic test_plain_bytes();
      byte_type text[$];
      // backslash on the last byte flushes as itself
      text = '{8'h00, 8'hFF, CHAR_BACKSLASH};
      send_string(text);
   endtask

   task automatic test_simple_escapes();
      byte_type text[$];
      // end on the escaped backslash so it decodes on the last byte
      foreach (escape_letters[i]) begin
         text.push_back(CHAR_BACKSLASH);
         text.push_back(escape_letters[i]);
      end
      send_string(text);
   endtask

   task automatic test_unknown_escape();
      byte_type text[$];
      text = '{CHAR_BACKSLASH, 8'hFF};
      send_string(text);
   endtask

   task automatic test_unicode_pass();
      byte_type text[$];
      // raw digits include a backslash; the escape after them decodes normally
      text = '{CHAR_BACKSLASH, CHAR_U, CHAR_BACKSLASH, 8'hFF, 8'h00, CHAR_U,
               CHAR_BACKSLASH, CHAR_N};
      send_string(text);
      // string ends on the u itself
      text = '{CHAR_BACKSLASH, CHAR_U};
      send_string(text);
   endtask

   task automatic test_backpressure();
      byte_type text[$];
      source_gaps = 1'b0;
      sink_gaps   = 1'b0;
      sink_hold   = LONG_HOLD;
      repeat (20) begin
         text.push_back(CHAR_BACKSLASH);
         text.push_back(byte_type'($urandom_range(8'h30, 8'h39)));
      end
      send_string(text);
      wait_drained();
   endtask

   task automatic test_random_strings();
      byte_type  text[$];
      int        sent;
      int        len;
      piece_type piece;
      sent = 0;
      source_gaps = 1'b1;
      sink_gaps   = 1'b1;
      while (sent < RANDOM_REQUESTS) begin
         if ($urandom_range(0, 14) == 0)
            {source_gaps, sink_gaps} = 2'($urandom_range(0, 3));
         text.delete();
         len = $urandom_range(1, 14);
         if ($urandom_range(0, 4) == 0) begin
            while (text.size() < len)
               text.push_back($urandom_range(0, 3) == 0 ? CHAR_BACKSLASH
                                                        : byte_type'($urandom_range(0, 255)));
         end else begin
            while (text.size() < len) begin
               piece = piece_type'($urandom_range(PIECE_PLAIN, PIECE_LONE));
               case (piece)
                  PIECE_PLAIN: begin
                     text.push_back(byte_type'($urandom_range(0, 255)));
                  end
                  PIECE_ESCAPE: begin
                     text.push_back(CHAR_BACKSLASH);
                     text.push_back(escape_letters[$urandom_range(0, 8)]);
                  end
                  PIECE_UNKNOWN: begin
                     text.push_back(CHAR_BACKSLASH);
                     text.push_back(byte_type'($urandom_range(0, 255)));
                  end
                  PIECE_UNICODE: begin
                     text.push_back(CHAR_BACKSLASH);
                     text.push_back(CHAR_U);
                     repeat (4)
                        text.push_back($urandom_range(0, 3) == 0 ? CHAR_BACKSLASH
                                                                 : byte_type'($urandom));
                  end
                  default: begin
                     text.push_back(CHAR_BACKSLASH);
                  end
               endcase
            end
            // cut some strings short inside an escape or unicode run
            if ($urandom_range(0, 2) == 0)
               while (text.size() > len) void'(text.pop_back());
         end
         send_string(text);
         sent += text.size();
      end
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.in_byte = '0;
      req_chan.in_last = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      source_gaps = 1'b1;
      sink_gaps   = 1'b1;
      test_plain_bytes();
      test_simple_escapes();
      test_unknown_escape();
      test_unicode_pass();
      wait_drained();
      test_backpressure();
      test_random_strings();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests in %0d strings, %0d decoded bytes checked",
               request_count, string_count, result_count);
      $display("with random gaps on both sides, a long receiver hold and a full drain");
      if (mismatch_count == 0 && decoded_bytes.size() == 0) begin
         $display("escape_sequence_decoder test passed");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatch_count, decoded_bytes.size());
         $display("escape_sequence_decoder test failed");
      end
      $finish;
   end

endmodule
